/* rtl/host_string_classifier_unit_assert.svh */
// Assertion macros shared by the host string classifier RTL.
`ifndef HOST_STRING_CLASSIFIER_UNIT_ASSERT_SVH
`define HOST_STRING_CLASSIFIER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define HSC_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hsc assertion failed");

// Next-cycle implication.
`define HSC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hsc assertion failed");

`endif

/* rtl/hsc_pkg.sv */
// Types, constants and the character classifier for the host string classifier.
package hsc_pkg;

   localparam int MAX_NAME_LENGTH  = 253;
   localparam int MAX_LABEL_LENGTH = 63;

   // Counters saturate one past their limit.
   localparam int TOTAL_W = $clog2(MAX_NAME_LENGTH + 2);
   localparam int LABEL_W = $clog2(MAX_LABEL_LENGTH + 2);

   localparam int OCTET_MAX  = 255;
   localparam int PREFIX_MAX = 32;

   localparam logic [15:0] CHAR_LF    = 16'h000A;
   localparam logic [15:0] CHAR_DOT   = 16'h002E;
   localparam logic [15:0] CHAR_SLASH = 16'h002F;
   localparam logic [15:0] CHAR_ZERO  = 16'h0030;
   localparam logic [15:0] CHAR_NINE  = 16'h0039;
   localparam logic [15:0] CHAR_HYPH  = 16'h002D;
   localparam logic [15:0] CHAR_UC_A  = 16'h0041;
   localparam logic [15:0] CHAR_UC_Z  = 16'h005A;
   localparam logic [15:0] CHAR_LC_A  = 16'h0061;
   localparam logic [15:0] CHAR_LC_Z  = 16'h007A;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_LETTER,
      CLS_DIGIT,
      CLS_HYPHEN
   } char_class_type;

   typedef enum logic [1:0] {
      PFX_NONE,
      PFX_SLASH,
      PFX_ONE,
      PFX_TWO
   } prefix_phase_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        no_char;
      logic        last;
   } req_data_type;

   typedef struct packed {
      logic is_ipv4;
      logic is_ipv4_cidr;
      logic is_domain;
      logic is_ip_or_domain;
      logic is_cidr_or_domain;
   } rsp_data_type;

   typedef struct packed {
      logic           is_dot;
      logic           is_slash;
      char_class_type cls;
      logic [3:0]     digit;
   } char_info_type;

   // take: character to parse; kill: character after the line feed;
   // count: any character; finish: last item, verdict and clear.
   typedef struct packed {
      logic take;
      logic kill;
      logic count;
      logic finish;
   } step_type;

   function automatic char_info_type classify(logic [15:0] c);
      char_info_type info;
      logic [15:0]   diff;
      diff          = c - CHAR_ZERO;
      info.is_dot   = (c == CHAR_DOT);
      info.is_slash = (c == CHAR_SLASH);
      info.digit    = diff[3:0];
      if ((c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z)) begin
         info.cls = CLS_LETTER;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         info.cls = CLS_DIGIT;
      end else if (c == CHAR_HYPH) begin
         info.cls = CLS_HYPHEN;
      end else begin
         info.cls = CLS_NONE;
      end
      return info;
   endfunction

endpackage

/* rtl/host_string_classifier_unit.sv */
// Host string classifier top level: request register, trackers, result register.
//
// Feed a host string one UTF-16 code unit per request, setting last on the
// final one; an empty string is a single request with no_char and last set.
// One request is taken every clock cycle unless a last request waits. Each request
// is registered, then the domain and dotted-quad trackers update their running
// state as it moves on; for a last request the verdicts land in the result
// register that same cycle and the trackers clear for the next string.
// Requests that are not last never wait on the result side; a last request
// waits only while an earlier result has not been taken.
`include "host_string_classifier_unit_assert.svh"

module host_string_classifier_unit
   import hsc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   logic          s1_valid_ff, s1_valid_in;
   req_data_type  s1_data_ff;
   logic          newline_ff, newline_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_data_type  rsp_data_ff, rsp_data_in;

   logic          out_free;
   logic          s1_move;
   logic          has_char;
   char_info_type info;
   step_type      step;
   logic          domain_ok, ipv4_ok, cidr_ok;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && (!s1_data_ff.last || out_free);
   assign req_ready = !s1_valid_ff || s1_move;
   assign info      = classify(s1_data_ff.code_unit);
   assign has_char  = s1_move && !s1_data_ff.no_char;

   always_comb begin
      step.count  = has_char;
      step.kill   = has_char && newline_ff;
      step.take   = has_char && !newline_ff && s1_data_ff.code_unit != CHAR_LF;
      step.finish = s1_move && s1_data_ff.last;

      s1_valid_in = (s1_valid_ff && !s1_move) || req_valid;

      newline_in = newline_ff || (has_char && s1_data_ff.code_unit == CHAR_LF);
      if (step.finish) begin
         newline_in = 1'b0;
      end

      rsp_data_in.is_ipv4           = ipv4_ok;
      rsp_data_in.is_ipv4_cidr      = cidr_ok;
      rsp_data_in.is_domain         = domain_ok;
      rsp_data_in.is_ip_or_domain   = ipv4_ok || domain_ok;
      rsp_data_in.is_cidr_or_domain = cidr_ok || domain_ok;

      if (step.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   hsc_domain u_domain (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .info      (info),
      .domain_ok (domain_ok)
   );

   hsc_ipv4 u_ipv4 (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .info    (info),
      .ipv4_ok (ipv4_ok),
      .cidr_ok (cidr_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         newline_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         newline_ff   <= newline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_ready) begin
         s1_data_ff <= req_data;
      end
      if (step.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HSC_ASSERT_IMPLY(a_ipv4_implies_cidr, rsp_valid_ff && rsp_data_ff.is_ipv4,
                     rsp_data_ff.is_ipv4_cidr)
   `HSC_ASSERT_IMPLY(a_cidr_excludes_domain, rsp_valid_ff && rsp_data_ff.is_ipv4_cidr,
                     !rsp_data_ff.is_domain)
   `HSC_ASSERT_IMPLY(a_or_verdicts, rsp_valid_ff,
                     rsp_data_ff.is_ip_or_domain ==
                     (rsp_data_ff.is_ipv4 || rsp_data_ff.is_domain) &&
                     rsp_data_ff.is_cidr_or_domain ==
                     (rsp_data_ff.is_ipv4_cidr || rsp_data_ff.is_domain))
   `HSC_ASSERT_NEXT(a_last_gives_result, s1_move && s1_data_ff.last, rsp_valid_ff)
   `HSC_ASSERT_IMPLY(a_last_held_on_stall,
                     s1_valid_ff && s1_data_ff.last && rsp_valid_ff && !rsp_ready,
                     !req_ready && !s1_move)

endmodule

/* rtl/hsc_domain.sv */
// Domain name tracker: label and total length checks, domain verdict.
module hsc_domain
   import hsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  step_type      step,
   input  char_info_type info,
   output logic          domain_ok
);

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               failed_ff, failed_in;
   logic               seen_dot_ff, seen_dot_in;
   logic [LABEL_W-1:0] label_len_ff, label_len_in;
   char_class_type     first_cls_ff, first_cls_in;
   char_class_type     prev_cls_ff, prev_cls_in;

   always_comb begin
      total_in     = total_ff;
      failed_in    = failed_ff;
      seen_dot_in  = seen_dot_ff;
      label_len_in = label_len_ff;
      first_cls_in = first_cls_ff;
      prev_cls_in  = prev_cls_ff;

      if (step.count && total_ff <= TOTAL_W'(MAX_NAME_LENGTH)) begin
         total_in = total_ff + TOTAL_W'(1);
      end

      if (step.kill) begin
         failed_in = 1'b1;
      end else if (step.take) begin
         if (info.is_dot) begin
            if (label_len_ff == '0 || label_len_ff > LABEL_W'(MAX_LABEL_LENGTH) ||
                first_cls_ff == CLS_HYPHEN || prev_cls_ff == CLS_HYPHEN) begin
               failed_in = 1'b1;
            end
            seen_dot_in  = 1'b1;
            label_len_in = '0;
            first_cls_in = CLS_NONE;
            prev_cls_in  = CLS_NONE;
         end else if (info.cls == CLS_NONE) begin
            failed_in   = 1'b1;
            prev_cls_in = CLS_NONE;
         end else begin
            if (label_len_ff == '0) begin
               first_cls_in = info.cls;
            end
            if (label_len_ff <= LABEL_W'(MAX_LABEL_LENGTH)) begin
               label_len_in = label_len_ff + LABEL_W'(1);
            end
            prev_cls_in = info.cls;
         end
      end

      domain_ok = !failed_in && seen_dot_in && label_len_in >= LABEL_W'(2) &&
                  first_cls_in == CLS_LETTER && prev_cls_in == CLS_LETTER &&
                  total_in <= TOTAL_W'(MAX_NAME_LENGTH);
   end

   always_ff @(posedge clock) begin
      if (reset || step.finish) begin
         total_ff     <= '0;
         failed_ff    <= 1'b0;
         seen_dot_ff  <= 1'b0;
         label_len_ff <= '0;
         first_cls_ff <= CLS_NONE;
         prev_cls_ff  <= CLS_NONE;
      end else begin
         total_ff     <= total_in;
         failed_ff    <= failed_in;
         seen_dot_ff  <= seen_dot_in;
         label_len_ff <= label_len_in;
         first_cls_ff <= first_cls_in;
         prev_cls_ff  <= prev_cls_in;
      end
   end

endmodule

/* rtl/hsc_ipv4.sv */
// Dotted-quad tracker: octet and prefix parsing, IPv4 and CIDR verdicts.
module hsc_ipv4
   import hsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  step_type      step,
   input  char_info_type info,
   output logic          ipv4_ok,
   output logic          cidr_ok
);

   logic [1:0]       octet_idx_ff, octet_idx_in;
   logic [1:0]       digits_ff, digits_in;
   logic [9:0]       octet_ff, octet_in;
   prefix_phase_type phase_ff, phase_in;
   logic [5:0]       prefix_ff, prefix_in;
   logic             v4_fail_ff, v4_fail_in;
   logic             cidr_fail_ff, cidr_fail_in;
   logic [6:0]       prefix_sum;

   always_comb begin
      octet_idx_in = octet_idx_ff;
      digits_in    = digits_ff;
      octet_in     = octet_ff;
      phase_in     = phase_ff;
      prefix_in    = prefix_ff;
      v4_fail_in   = v4_fail_ff;
      cidr_fail_in = cidr_fail_ff;
      prefix_sum   = 7'(prefix_ff[3:0]) * 7'd10 + 7'(info.digit);

      if (step.kill) begin
         v4_fail_in   = 1'b1;
         cidr_fail_in = 1'b1;
      end else if (step.take) begin
         if (info.is_dot) begin
            if (phase_ff != PFX_NONE || digits_ff == 2'd0 || octet_idx_ff == 2'd3) begin
               v4_fail_in   = 1'b1;
               cidr_fail_in = 1'b1;
            end else begin
               if (octet_ff > 10'(OCTET_MAX)) begin
                  v4_fail_in = 1'b1;
               end
               octet_idx_in = octet_idx_ff + 2'd1;
            end
            digits_in = 2'd0;
            octet_in  = '0;
         end else if (info.is_slash) begin
            v4_fail_in = 1'b1;
            if (phase_ff != PFX_NONE || octet_idx_ff != 2'd3 || digits_ff == 2'd0) begin
               cidr_fail_in = 1'b1;
            end else begin
               phase_in = PFX_SLASH;
            end
         end else if (info.cls != CLS_DIGIT) begin
            v4_fail_in   = 1'b1;
            cidr_fail_in = 1'b1;
         end else begin
            unique case (phase_ff)
               PFX_NONE: begin
                  if (digits_ff == 2'd3) begin
                     v4_fail_in   = 1'b1;
                     cidr_fail_in = 1'b1;
                  end else begin
                     digits_in = digits_ff + 2'd1;
                     octet_in  = octet_ff * 10'd10 + 10'(info.digit);
                  end
               end
               PFX_SLASH: begin
                  phase_in  = PFX_ONE;
                  prefix_in = 6'(info.digit);
               end
               PFX_ONE: begin
                  phase_in = PFX_TWO;
                  if (prefix_ff == '0 || prefix_sum > 7'(PREFIX_MAX)) begin
                     cidr_fail_in = 1'b1;
                  end
                  prefix_in = prefix_sum[5:0];
               end
               PFX_TWO: begin
                  cidr_fail_in = 1'b1;
               end
            endcase
         end
      end

      ipv4_ok = !v4_fail_in && octet_idx_in == 2'd3 && digits_in != 2'd0 &&
                octet_in <= 10'(OCTET_MAX) && phase_in == PFX_NONE;
      cidr_ok = !cidr_fail_in && octet_idx_in == 2'd3 && digits_in != 2'd0 &&
                phase_in != PFX_SLASH;
   end

   always_ff @(posedge clock) begin
      if (reset || step.finish) begin
         octet_idx_ff <= '0;
         digits_ff    <= '0;
         octet_ff     <= '0;
         phase_ff     <= PFX_NONE;
         prefix_ff    <= '0;
         v4_fail_ff   <= 1'b0;
         cidr_fail_ff <= 1'b0;
      end else begin
         octet_idx_ff <= octet_idx_in;
         digits_ff    <= digits_in;
         octet_ff     <= octet_in;
         phase_ff     <= phase_in;
         prefix_ff    <= prefix_in;
         v4_fail_ff   <= v4_fail_in;
         cidr_fail_ff <= cidr_fail_in;
      end
   end

endmodule
